// ----- rtl/rerq_pkg.sv -----
// Shared types and codes for the event retransmit queue.
`timescale 1ns / 1ps
package rerq_pkg;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_TICK    = 2'd1,
		OP_ACK     = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_SEND      = 3'd0,
		KIND_ENQ_DONE  = 3'd1,
		KIND_ACK_DONE  = 3'd2,
		KIND_TICK_DONE = 3'd3,
		KIND_CLR_DONE  = 3'd4
	} kind_t;

	localparam int unsigned REG_RESEND_INTERVAL = 0;
	localparam int unsigned REG_RESEND_LIMIT    = 1;
	localparam logic [15:0] INTERVAL_RESET = 16'd500;
	localparam logic [4:0]  LIMIT_RESET    = 5'd16;
	localparam logic [4:0]  CNT_MAX        = 5'd31;

	typedef struct packed {
		logic [31:0] sent_time;
		logic [9:0]  size;
		logic [15:0] tag;
		logic [4:0]  cnt;
		logic        cls;
		logic [7:0]  seq;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  seq;
		logic        cls;
		logic [15:0] tag;
		logic [9:0]  size;
		logic        resend;
		logic        ok;
		logic [4:0]  disc;
		logic        last;
	} result_t;

endpackage

// ----- rtl/rerq_entry_ram.sv -----
// Entry store of the retransmit queue: one write port, one registered read port.
`timescale 1ns / 1ps
module rerq_entry_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rerq_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output rerq_pkg::entry_t rdata
);
	import rerq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/rerq_age_cmp.sv -----
// Shared age unit: wrapping age of an entry compared against the resend interval.
`timescale 1ns / 1ps
module rerq_age_cmp (
	input  logic [31:0] now,
	input  logic [31:0] sent_time,
	input  logic [15:0] interval,
	output logic        expired
);
	logic [31:0] age;

	assign age     = now - sent_time;
	assign expired = age > {16'd0, interval};

endmodule

// ----- rtl/reliable_event_retransmit_queue.sv -----
// Top level of the event retransmit queue: sequencer, config and output register.
`timescale 1ns / 1ps
// Enqueue and clear go straight to the final result. Acknowledgement makes one pass over the queued events.
// Tick makes two passes over the entry memory, each entry read, then updated (in the second pass
// through the shared age unit); a send waits while the output register holds an unaccepted result.
// One transaction at a time; s_tready is high only when the sequencer is idle.
// Reset (arst_n low) empties the queue, zeroes both sequence counters and loads
// the registers with interval 500 and limit 16; the entry memory is not cleared.
module reliable_event_retransmit_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // in_order, ack_sequence[8], payload_tag[16],
	                              // payload_size[10], now[32], zero pad
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // msg_sequence[8], msg_in_order, msg_tag[16],
	                              // msg_size[10], is_resend, success, discarded[5], pad
	output logic [2:0]  m_tuser,  // result_kind
	output logic        m_tlast
);
	import rerq_pkg::*;

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EX,
		ST_FIN
	} state_t;

	state_t      state_q;
	logic [15:0] interval_q;
	logic [4:0]  limit_q;
	logic [CW-1:0] count_q, rd_q, wr_q;
	logic [7:0]  oseq_q, useq_q;
	opcode_t     op_q;
	logic        cls_q;
	logic [7:0]  ackseq_q;
	logic [31:0] now_q;
	logic        phase_q;   // tick: 0 first sends, 1 resends
	logic        found_q;   // ack hit, or enqueue accepted
	logic [7:0]  enq_seq_q;
	logic [4:0]  disc_q;
	result_t     out_q;
	logic        out_v_q;

	// input unpack
	opcode_t     in_op;
	logic        in_cls;
	logic [7:0]  in_ack;
	logic [15:0] in_tag;
	logic [9:0]  in_size;
	logic [31:0] in_now;
	assign in_op   = opcode_t'(s_tuser);
	assign in_cls  = s_tdata[0];
	assign in_ack  = s_tdata[8:1];
	assign in_tag  = s_tdata[24:9];
	assign in_size = s_tdata[34:25];
	assign in_now  = s_tdata[66:35];

	logic accept, out_free, full;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign full     = (count_q == FULL);

	// memory
	logic    mem_we, mem_re;
	logic [AW-1:0] mem_waddr;
	entry_t  mem_wdata, ent;
	assign mem_re = (state_q == ST_RD) && (rd_q < count_q);

	rerq_entry_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_q[AW-1:0]),
		.rdata (ent)
	);

	logic expired;
	rerq_age_cmp u_age (
		.now       (now_q),
		.sent_time (ent.sent_time),
		.interval  (interval_q),
		.expired   (expired)
	);

	// per-entry decision in the execute step
	logic [4:0] cnt_inc;
	logic       ex_emit, ex_keep, ex_drop, ex_hit, ex_stall;
	entry_t     ex_entry, enq_entry;
	assign cnt_inc = (ent.cnt == CNT_MAX) ? CNT_MAX : ent.cnt + 5'd1;

	always_comb begin
		ex_emit  = 1'b0;
		ex_keep  = 1'b1;
		ex_drop  = 1'b0;
		ex_hit   = 1'b0;
		ex_entry = ent;
		if (op_q == OP_TICK && !phase_q) begin
			ex_emit = (ent.cnt == 5'd0);
			ex_keep = ex_emit;
			ex_entry.sent_time = now_q;
			ex_entry.cnt       = 5'd1;
		end else if (op_q == OP_TICK) begin
			ex_emit = expired;
			if (expired) begin
				ex_entry.sent_time = now_q;
				ex_entry.cnt       = cnt_inc;
			end
			ex_drop = expired && !ent.cls && (cnt_inc >= limit_q);
			ex_keep = !ex_drop;
		end else begin
			ex_hit  = !found_q && (ent.cls == cls_q) && (ent.seq == ackseq_q);
			ex_keep = !ex_hit;
		end
	end
	assign ex_stall = ex_emit && !out_free;

	// load the output register with a send or with the final result
	logic out_load;
	assign out_load = ((state_q == ST_EX) && ex_emit && !ex_stall)
	               || ((state_q == ST_FIN) && out_free);

	assign enq_entry = '{sent_time: 32'd0, size: in_size, tag: in_tag, cnt: 5'd0,
	                     cls: in_cls, seq: in_cls ? oseq_q : useq_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = enq_entry;
		if (state_q == ST_IDLE) begin
			mem_we = accept && (in_op == OP_ENQUEUE) && !full;
		end else if (state_q == ST_EX) begin
			mem_we    = ex_keep && !ex_stall;
			mem_wdata = ex_entry;
			mem_waddr = (op_q == OP_TICK && !phase_q) ? rd_q[AW-1:0] : wr_q[AW-1:0];
		end
	end

	// final result of the transaction
	result_t fin_res, send_res;
	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		unique case (op_q)
			OP_ENQUEUE: begin
				fin_res.kind = KIND_ENQ_DONE;
				fin_res.seq  = enq_seq_q;
				fin_res.cls  = cls_q;
				fin_res.ok   = found_q;
			end
			OP_TICK: begin
				fin_res.kind = KIND_TICK_DONE;
				fin_res.disc = disc_q;
			end
			OP_ACK: begin
				fin_res.kind = KIND_ACK_DONE;
				fin_res.ok   = found_q;
			end
			OP_CLEAR: fin_res.kind = KIND_CLR_DONE;
			default:  fin_res.kind = KIND_CLR_DONE;
		endcase
		send_res        = '0;
		send_res.kind   = KIND_SEND;
		send_res.seq    = ent.seq;
		send_res.cls    = ent.cls;
		send_res.tag    = ent.tag;
		send_res.size   = ent.size;
		send_res.resend = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			interval_q <= INTERVAL_RESET;
			limit_q    <= LIMIT_RESET;
			count_q    <= '0;
			oseq_q     <= '0;
			useq_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			phase_q    <= 1'b0;
			found_q    <= 1'b0;
			disc_q     <= '0;
			op_q       <= OP_CLEAR;
			cls_q      <= 1'b0;
			ackseq_q   <= '0;
			now_q      <= '0;
			enq_seq_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(REG_RESEND_INTERVAL)) begin
					interval_q <= cfg_data;
				end else begin
					limit_q <= cfg_data[4:0];
				end
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= in_op;
						cls_q    <= in_cls;
						ackseq_q <= in_ack;
						now_q    <= in_now;
						rd_q     <= '0;
						wr_q     <= '0;
						phase_q  <= 1'b0;
						found_q  <= 1'b0;
						disc_q   <= '0;
						enq_seq_q <= '0;
						unique case (in_op)
							OP_ENQUEUE: begin
								state_q <= ST_FIN;
								if (!full) begin
									found_q   <= 1'b1;
									count_q   <= count_q + CW'(1);
									enq_seq_q <= in_cls ? oseq_q : useq_q;
									if (in_cls) begin
										oseq_q <= oseq_q + 8'd1;
									end else begin
										useq_q <= useq_q + 8'd1;
									end
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								oseq_q  <= '0;
								useq_q  <= '0;
								state_q <= ST_FIN;
							end
							default: state_q <= ST_RD;
						endcase
					end
				end
				ST_RD: begin
					if (rd_q < count_q) begin
						state_q <= ST_EX;
					end else if (op_q == OP_TICK && !phase_q) begin
						phase_q <= 1'b1;
						rd_q    <= '0;
						wr_q    <= '0;
					end else begin
						count_q <= wr_q;
						state_q <= ST_FIN;
					end
				end
				ST_EX: begin
					if (!ex_stall) begin
						if (ex_emit) begin
							out_q <= send_res;
						end
						if (ex_keep) begin
							wr_q <= wr_q + CW'(1);
						end
						if (ex_hit) begin
							found_q <= 1'b1;
						end
						if (ex_drop && disc_q != CNT_MAX) begin
							disc_q <= disc_q + 5'd1;
						end
						rd_q    <= rd_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q   <= fin_res;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {6'd0, out_q.disc, out_q.ok, out_q.resend, out_q.size, out_q.tag,
	                   out_q.cls, out_q.seq};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("queue count beyond depth");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX) |-> (wr_q <= rd_q)) else $error("write index passed read index");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("ready right after accept");
`endif

endmodule

// ----- sim/tb_reliable_event_retransmit_queue.sv -----
// Self-checking testbench for the event retransmit queue: directed and random traffic.
`timescale 1ns / 1ps
module tb_reliable_event_retransmit_queue;
	import rerq_pkg::*;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RANDOM_ITEMS = 380;

	// One request as seen on the slave side
	typedef struct {
		opcode_t     op;
		bit          cls;
		bit [7:0]    ack_seq;
		bit [15:0]   tag;
		bit [9:0]    size;
		bit [31:0]   now;
	} request_t;

	// One result as seen on the master side
	typedef struct {
		kind_t       kind;
		bit [7:0]    seq;
		bit          cls;
		bit [15:0]   tag;
		bit [9:0]    size;
		bit          resend;
		bit          ok;
		bit [4:0]    disc;
		bit          last;
	} outcome_t;

	// One queued event held by the predictor
	typedef struct {
		bit [7:0]    seq;
		bit          cls;
		bit [15:0]   tag;
		bit [9:0]    size;
		bit [4:0]    cnt;
		bit [31:0]   sent_at;
	} event_t;

	class retransmit_scoreboard;
		event_t      events[$];
		outcome_t    expected_outcomes[$];
		bit [7:0]    ordered_seq;
		bit [7:0]    unordered_seq;
		bit [15:0]   interval;
		bit [4:0]    limit;
		int          errors;

		function void reset_state();
			events.delete();
			ordered_seq = '0;
			unordered_seq = '0;
			interval = INTERVAL_RESET;
			limit = LIMIT_RESET;
		endfunction

		function void push(kind_t k, bit [7:0] s, bit c, bit [15:0] t, bit [9:0] z,
				bit rs, bit ok, bit [4:0] d, bit l);
			outcome_t o;
			o.kind = k; o.seq = s; o.cls = c; o.tag = t; o.size = z;
			o.resend = rs; o.ok = ok; o.disc = d; o.last = l;
			expected_outcomes.insert(expected_outcomes.size(), o);
		endfunction

		// Predict every result that one accepted transaction causes
		function void note_request(request_t r);
			int i;
			bit [31:0] age;
			bit [4:0] disc;
			bit [7:0] s;
			bit hit;
			case (r.op)
				OP_ENQUEUE: begin
					if (events.size() >= DEPTH) begin
						push(KIND_ENQ_DONE, 0, r.cls, 0, 0, 0, 0, 0, 1);
					end else begin
						event_t e;
						if (r.cls) begin
							s = ordered_seq; ordered_seq++;
						end else begin
							s = unordered_seq; unordered_seq++;
						end
						e.seq = s; e.cls = r.cls; e.tag = r.tag; e.size = r.size;
						e.cnt = 0; e.sent_at = 0;
						events.insert(events.size(), e);
						push(KIND_ENQ_DONE, s, r.cls, 0, 0, 0, 1, 0, 1);
					end
				end
				OP_TICK: begin
					disc = 0;
					// first pass: initial sends, stamp with current time
					for (i = 0; i < events.size(); i++) begin
						if (events[i].cnt == 0) begin
							push(KIND_SEND, events[i].seq, events[i].cls, events[i].tag,
								events[i].size, 0, 0, 0, 0);
							events[i].sent_at = r.now;
							events[i].cnt = 1;
						end
					end
					// second pass: resend aged events, drop exhausted unordered ones
					i = 0;
					while (i < events.size()) begin
						age = r.now - events[i].sent_at;
						if (age > interval) begin
							push(KIND_SEND, events[i].seq, events[i].cls, events[i].tag,
								events[i].size, 1, 0, 0, 0);
							events[i].sent_at = r.now;
							if (events[i].cnt != CNT_MAX) events[i].cnt++;
							if (!events[i].cls && events[i].cnt >= limit) begin
								events.delete(i);
								if (disc != CNT_MAX) disc++;
								continue;
							end
						end
						i++;
					end
					push(KIND_TICK_DONE, 0, 0, 0, 0, 0, 0, disc, 1);
				end
				OP_ACK: begin
					hit = 0;
					for (i = 0; i < events.size(); i++) begin
						if (events[i].cls == r.cls && events[i].seq == r.ack_seq) begin
							events.delete(i);
							hit = 1;
							break;
						end
					end
					push(KIND_ACK_DONE, 0, 0, 0, 0, 0, hit, 0, 1);
				end
				default: begin
					events.delete();
					ordered_seq = '0;
					unordered_seq = '0;
					push(KIND_CLR_DONE, 0, 0, 0, 0, 0, 0, 0, 1);
				end
			endcase
		endfunction

		// Compare one accepted result against the oldest prediction
		function void check_result(logic [2:0] kind, logic [47:0] data, logic last);
			outcome_t e;
			outcome_t a;
			bit bad;
			a.kind = kind_t'(kind);
			a.seq = data[7:0]; a.cls = data[8]; a.tag = data[24:9]; a.size = data[34:25];
			a.resend = data[35]; a.ok = data[36]; a.disc = data[41:37]; a.last = last;
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $realtime, a);
				errors++;
				return;
			end
			e = expected_outcomes.pop_front();
			bad = (kind !== e.kind) || (data[7:0] !== e.seq) || (data[8] !== e.cls)
				|| (data[24:9] !== e.tag) || (data[34:25] !== e.size)
				|| (data[35] !== e.resend) || (data[36] !== e.ok)
				|| (data[41:37] !== e.disc) || (data[47:42] !== 6'd0) || (last !== e.last);
			if (bad) begin
				$display("%0t: result mismatch, expected %p, actual %p", $realtime, e, a);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	retransmit_scoreboard sb;
	int unsigned cycles;
	int unsigned rx_stall;
	bit          quiet;      // no idling on either side while set
	bit [31:0]   clock_ms;   // running time base handed to ticks

	reliable_event_retransmit_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Result side: hold tready low for a random stall, then accept and check
	initial begin
		m_tready = 1'b0;
		rx_stall = 0;
		forever begin
			@(negedge clk);
			if (rx_stall > 0) begin
				m_tready = 1'b0;
				rx_stall--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata, m_tlast);
				rx_stall = quiet ? 0 : $urandom_range(0, 4);
			end
		end
	end

	// Drive one transaction after a random gap; predict on acceptance
	task automatic send_request(request_t r);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		repeat (gap) @(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = r.op;
		s_tdata = {5'd0, r.now, r.size, r.tag, r.ack_seq, r.cls};
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Fill a request with random content in every field, then set what matters
	function automatic request_t random_request(opcode_t op);
		request_t r;
		r.op = op;
		r.cls = 1'($urandom_range(0, 1));
		r.ack_seq = 8'($urandom);
		r.tag = 16'($urandom);
		r.size = 10'($urandom);
		r.now = $urandom;
		return r;
	endfunction

	// Advance the time base: mostly forward, sometimes on the boundary, sometimes back
	function automatic bit [31:0] next_time();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: clock_ms += $urandom_range(0, sb.interval);
			4, 5, 6:    clock_ms += sb.interval + 1 + $urandom_range(0, 50);
			7:          clock_ms += sb.interval;
			8:          clock_ms = $urandom;
			default:    clock_ms -= $urandom_range(1, 1000);
		endcase
		return clock_ms;
	endfunction

	// Let all pending results drain so that a register write lands on an idle block
	task automatic drain();
		while (sb.expected_outcomes.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(int unsigned idx, bit [15:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx[0];
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_RESEND_INTERVAL) sb.interval = value;
		else sb.limit = value[4:0];
	endtask

	task automatic random_phase(int unsigned count);
		request_t r;
		int unsigned pick;
		int unsigned idx;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 39) == 0) quiet = ~quiet;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r = random_request(OP_ENQUEUE);
			end else if (pick < 75) begin
				r = random_request(OP_TICK);
				r.now = next_time();
			end else if (pick < 96) begin
				r = random_request(OP_ACK);
				// mostly acknowledge an event that is really queued
				if (sb.events.size() != 0 && $urandom_range(0, 9) < 7) begin
					idx = $urandom_range(0, sb.events.size() - 1);
					r.cls = sb.events[idx].cls;
					r.ack_seq = sb.events[idx].seq;
				end
			end else begin
				r = random_request(OP_CLEAR);
			end
			send_request(r);
		end
	endtask

	initial begin
		request_t r;
		sb = new();
		sb.errors = 0;
		sb.reset_state();
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ENQUEUE;
		clock_ms = 32'hFFFF_FE00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill past capacity with field extremes, full-queue flag
		for (int n = 0; n < DEPTH + 1; n++) begin
			r = random_request(OP_ENQUEUE);
			r.cls = n[0];
			r.tag = n[1] ? 16'hFFFF : 16'h0000;
			r.size = n[1] ? 10'h3FF : 10'h000;
			send_request(r);
		end
		// first sends, then a resend just past the interval across the clock wrap
		r = random_request(OP_TICK); r.now = 32'hFFFF_FF00; send_request(r);
		r = random_request(OP_TICK); r.now = 32'hFFFF_FF00 + 32'd500; send_request(r);
		r = random_request(OP_TICK); r.now = 32'hFFFF_FF00 + 32'd501; send_request(r);
		// matched and unmatched acknowledgements
		r = random_request(OP_ACK); r.cls = 1'b1; r.ack_seq = 8'd0; send_request(r);
		r = random_request(OP_ACK); r.cls = 1'b1; r.ack_seq = 8'd0; send_request(r);
		// clock stepping back looks very old
		r = random_request(OP_TICK); r.now = 32'd0; send_request(r);
		r = random_request(OP_CLEAR); send_request(r);

		// Random phases over several register settings, extremes included
		random_phase(RANDOM_ITEMS / 5);
		drain();
		write_reg(REG_RESEND_INTERVAL, 16'd1);
		write_reg(REG_RESEND_LIMIT, 16'd31);
		random_phase(RANDOM_ITEMS / 5);
		drain();
		write_reg(REG_RESEND_INTERVAL, 16'hFFFF);
		write_reg(REG_RESEND_LIMIT, 16'd1);
		random_phase(RANDOM_ITEMS / 5);
		drain();
		write_reg(REG_RESEND_INTERVAL, 16'd20);
		write_reg(REG_RESEND_LIMIT, 16'd0);
		random_phase(RANDOM_ITEMS / 5);
		drain();
		write_reg(REG_RESEND_INTERVAL, 16'd100);
		write_reg(REG_RESEND_LIMIT, 16'd3);
		random_phase(RANDOM_ITEMS / 5);

		// Wait for every predicted result, then a short tail for strays
		while (sb.expected_outcomes.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.expected_outcomes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
